>>> rtl/preemptive_priority_scheduler_unit_macros.svh
// assertion helpers shared by the scheduler rtl
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PPSU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PPSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppsu_pkg.sv
// ----------------------------------------------------------------------------
// ppsu_pkg
// shared constants and controller/datapath interface types for the scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppsu_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int TIME_BITS_DEF     = 16;

    localparam int IN_TIME_W   = 16;
    localparam int PRIORITY_W  = 8;
    localparam int JOB_INDEX_W = 6;
    localparam int OUT_TIME_W  = 21;

    localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = {OUT_TIME_W{1'b1}};

    // arrival, burst, priority
    localparam int S_TDATA_W = 40;
    // job index, completion, waiting, turnaround, padded to bytes
    localparam int M_TDATA_W = 72;

    typedef struct packed {
        logic load;         // write the incoming job into the stores
        logic sched_start;  // clear tick and scan results for a new set
        logic eval;         // store read data is valid, fold into scan
        logic prep;         // compute gap to next arrival
        logic update;       // apply the chosen run length
        logic out_load;     // load the result register
        logic out_last;     // current result is the final one
    } ppsu_cmd_t;

    typedef struct packed {
        logic done;         // last scan found no pending job
        logic out_free;     // result register can take a beat
    } ppsu_stat_t;

endpackage

>>> rtl/preemptive_priority_scheduler_unit.sv
// loading: jobs are taken only while the sequencer is idle; a schedule pass
// scans all n jobs and a set needs at most 2n + 1 passes (finishes, arrival
// preemptions, idle jumps); the scan walks the job store read port
// readout: a store read, then a result load per beat, held while the beat is untaken
// reset: aresetn clears sequencer, job count, tick and result valid; job stores
// are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// loads a job set, runs a preemptive priority schedule, streams per-job times
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_unit_macros.svh"

module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCESSES = ppsu_pkg::MAX_PROCESSES_DEF,
    parameter int TIME_BITS     = ppsu_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // job load channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppsu_pkg::S_TDATA_W-1:0] s_tdata,   // arrival_time, burst_time, priority_level
    input  logic                           s_tlast,   // last_job
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppsu_pkg::M_TDATA_W-1:0] m_tdata,   // job_index, completion_time,
                                                      // waiting_time, turnaround_time, pad
    output logic                           m_tlast    // last_result
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);

    // sequencer to datapath commands and status
    ppsu_pkg::ppsu_cmd_t  cmd;
    ppsu_pkg::ppsu_stat_t stat;

    // shared read address: scan index during passes, result index during readout
    logic [IDX_W-1:0] rd_addr;
    // slot for the next loaded job
    logic [IDX_W-1:0] wr_slot;

    ppsu_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_slot  (wr_slot)
    );

    ppsu_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .TIME_BITS     (TIME_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .rd_addr  (rd_addr),
        .wr_slot  (wr_slot),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // loads and service updates share the store write port
    `PPSU_ASSERT_SAME(a_load_vs_update, aclk, aresetn, cmd.load, !cmd.update, "load collides with schedule update")
    // once a set starts scheduling no further job is taken
    `PPSU_ASSERT_NEXT(a_start_blocks_load, aclk, aresetn, cmd.sched_start, !s_tready, "job accepted during schedule")
    // a result beat is never overwritten before it is taken
    `PPSU_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, (!m_tvalid || m_tready), "result beat overwritten")

endmodule

>>> rtl/ppsu_ram.sv
// ----------------------------------------------------------------------------
// ppsu_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ppsu_ctrl.sv
// ----------------------------------------------------------------------------
// ppsu_ctrl
// sequencer for loading, scan passes and result readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsu_ctrl #(
    parameter int MAX_PROCESSES = ppsu_pkg::MAX_PROCESSES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tlast,
    output logic                             s_tready,
    input  ppsu_pkg::ppsu_stat_t             stat,
    output ppsu_pkg::ppsu_cmd_t              cmd,
    output logic [$clog2(MAX_PROCESSES)-1:0] rd_addr,
    output logic [$clog2(MAX_PROCESSES)-1:0] wr_slot
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_PREP   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_OREAD  = 3'd5;
    localparam logic [2:0] S_OLOAD  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             eval_reg, eval_next;
    logic             at_last;
    logic             accept;
    logic [CNT_W-1:0] count_plus;

    assign accept     = s_tvalid && s_tready;
    assign count_plus = count_reg + CNT_W'(1);
    assign at_last    = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    assign s_tready = (state_reg == S_IDLE);
    assign rd_addr  = idx_reg;
    assign wr_slot  = count_reg[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        eval_next  = (state_reg == S_SCAN);
        cmd        = '0;
        cmd.eval   = eval_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    count_next = count_plus;
                    if (s_tlast || (count_plus == CNT_W'(MAX_PROCESSES))) begin
                        cmd.sched_start = 1'b1;
                        idx_next        = '0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (at_last) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                idx_next   = '0;
                state_next = stat.done ? S_OREAD : S_SCAN;
            end
            S_OREAD: begin
                state_next = S_OLOAD;
            end
            S_OLOAD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = at_last;
                    if (at_last) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_OREAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            eval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            eval_reg  <= eval_next;
        end
    end

endmodule

>>> rtl/ppsu_datapath.sv
// ----------------------------------------------------------------------------
// ppsu_datapath
// job stores, scan compare, tick arithmetic and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppsu_datapath #(
    parameter int MAX_PROCESSES = ppsu_pkg::MAX_PROCESSES_DEF,
    parameter int TIME_BITS     = ppsu_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ppsu_pkg::ppsu_cmd_t              cmd,
    output ppsu_pkg::ppsu_stat_t             stat,
    input  logic [$clog2(MAX_PROCESSES)-1:0] rd_addr,
    input  logic [$clog2(MAX_PROCESSES)-1:0] wr_slot,
    input  logic [ppsu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [ppsu_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int IDX_W  = $clog2(MAX_PROCESSES);
    localparam int PRI_W  = ppsu_pkg::PRIORITY_W;
    localparam int TICK_W = TIME_BITS + $clog2(MAX_PROCESSES) + 1;
    localparam int JOB_W  = PRI_W + 2 * TIME_BITS;
    localparam int OUT_W  = ppsu_pkg::OUT_TIME_W;
    localparam int SAT_W  = (TICK_W > OUT_W) ? TICK_W : OUT_W;
    localparam int PAD_W  = ppsu_pkg::M_TDATA_W - ppsu_pkg::JOB_INDEX_W - 3 * OUT_W;

    // incoming job fields, low TIME_BITS bits kept
    logic [TIME_BITS-1:0] in_arr, in_burst;
    logic [PRI_W-1:0]     in_pri;

    assign in_arr   = TIME_BITS'(s_tdata[15:0]);
    assign in_burst = TIME_BITS'(s_tdata[31:16]);
    assign in_pri   = s_tdata[39:32];

    // store ports
    logic [IDX_W-1:0]     wr_addr;
    logic [JOB_W-1:0]     job_rd;
    logic [TIME_BITS-1:0] rem_rd, rem_wr_data;
    logic [TICK_W-1:0]    comp_rd, comp_wr_data;
    logic                 rem_wr_en, comp_wr_en;
    logic [TIME_BITS-1:0] rd_arr, rd_burst;
    logic [PRI_W-1:0]     rd_pri;

    assign rd_arr   = job_rd[TIME_BITS-1:0];
    assign rd_burst = job_rd[2*TIME_BITS-1:TIME_BITS];
    assign rd_pri   = job_rd[JOB_W-1:2*TIME_BITS];

    // scan and tick state
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 pick_valid_reg, pick_valid_next;
    logic                 next_valid_reg, next_valid_next;
    logic [IDX_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [PRI_W-1:0]     pick_pri_reg, pick_pri_next;
    logic [TIME_BITS-1:0] pick_rem_reg, pick_rem_next;
    logic [TIME_BITS-1:0] next_arr_reg, next_arr_next;
    logic [TIME_BITS-1:0] gap_reg, gap_next;
    logic [IDX_W-1:0]     eval_idx_reg;

    assign wr_addr  = cmd.load ? wr_slot : pick_idx_reg;

    // result register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [ppsu_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                 active, arrived, preempt;
    logic [TICK_W-1:0]    tick_full;
    logic [TICK_W-1:0]    res_turn, res_wait;

    function automatic logic [OUT_W-1:0] sat_time(input logic [TICK_W-1:0] v);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(v);
        if (ext > SAT_W'(ppsu_pkg::OUT_TIME_MAX)) begin
            return ppsu_pkg::OUT_TIME_MAX;
        end
        return OUT_W'(ext);
    endfunction

    assign active    = (rem_rd != '0);
    assign arrived   = (TICK_W'(rd_arr) <= tick_reg);
    assign preempt   = next_valid_reg && (gap_reg < pick_rem_reg);
    assign tick_full = tick_reg + TICK_W'(pick_rem_reg);
    assign res_turn  = comp_rd - TICK_W'(rd_arr);
    assign res_wait  = res_turn - TICK_W'(rd_burst);

    // store writes: load fills a slot, update retires service on the pick
    always_comb begin
        rem_wr_en    = 1'b0;
        rem_wr_data  = in_burst;
        comp_wr_en   = 1'b0;
        comp_wr_data = TICK_W'(in_arr);
        if (cmd.load) begin
            rem_wr_en  = 1'b1;
            // a job with no service finishes on arrival
            comp_wr_en = (in_burst == '0);
        end else if (cmd.update && pick_valid_reg) begin
            rem_wr_en = 1'b1;
            if (preempt) begin
                rem_wr_data = pick_rem_reg - gap_reg;
            end else begin
                rem_wr_data  = '0;
                comp_wr_en   = 1'b1;
                comp_wr_data = tick_full;
            end
        end
    end

    always_comb begin
        tick_next       = tick_reg;
        pick_valid_next = pick_valid_reg;
        next_valid_next = next_valid_reg;
        pick_idx_next   = pick_idx_reg;
        pick_pri_next   = pick_pri_reg;
        pick_rem_next   = pick_rem_reg;
        next_arr_next   = next_arr_reg;
        gap_next        = gap_reg;
        if (cmd.sched_start) begin
            tick_next       = '0;
            pick_valid_next = 1'b0;
            next_valid_next = 1'b0;
        end
        if (cmd.eval && active) begin
            if (arrived) begin
                // strict compare keeps the lowest index on a tie
                if (!pick_valid_reg || (rd_pri > pick_pri_reg)) begin
                    pick_valid_next = 1'b1;
                    pick_idx_next   = eval_idx_reg;
                    pick_pri_next   = rd_pri;
                    pick_rem_next   = rem_rd;
                end
            end else if (!next_valid_reg || (rd_arr < next_arr_reg)) begin
                next_valid_next = 1'b1;
                next_arr_next   = rd_arr;
            end
        end
        if (cmd.prep) begin
            gap_next = TIME_BITS'(TICK_W'(next_arr_reg) - tick_reg);
        end
        if (cmd.update) begin
            if (pick_valid_reg && !preempt) begin
                tick_next = tick_full;
            end else if (next_valid_reg) begin
                // run up to the next arrival, or idle until it
                tick_next = TICK_W'(next_arr_reg);
            end
            pick_valid_next = 1'b0;
            next_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = cmd.out_last;
            m_tdata_next  = {{PAD_W{1'b0}}, sat_time(res_turn), sat_time(res_wait),
                             sat_time(comp_rd), ppsu_pkg::JOB_INDEX_W'(rd_addr)};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            pick_valid_reg <= 1'b0;
            next_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            tick_reg       <= tick_next;
            pick_valid_reg <= pick_valid_next;
            next_valid_reg <= next_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_idx_reg <= pick_idx_next;
        pick_pri_reg <= pick_pri_next;
        pick_rem_reg <= pick_rem_next;
        next_arr_reg <= next_arr_next;
        gap_reg      <= gap_next;
        eval_idx_reg <= rd_addr;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign stat.done     = !pick_valid_reg && !next_valid_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // priority, burst, arrival
    ppsu_ram #(.WIDTH(JOB_W), .DEPTH(MAX_PROCESSES)) u_job_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load),
        .wr_addr (wr_slot),
        .wr_data ({in_pri, in_burst, in_arr}),
        .rd_addr (rd_addr),
        .rd_data (job_rd)
    );

    ppsu_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_rem_ram (
        .aclk    (aclk),
        .wr_en   (rem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (rem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rem_rd)
    );

    ppsu_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCESSES)) u_comp_ram (
        .aclk    (aclk),
        .wr_en   (comp_wr_en),
        .wr_addr (wr_addr),
        .wr_data (comp_wr_data),
        .rd_addr (rd_addr),
        .rd_data (comp_rd)
    );

endmodule

>>> verif/schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schedule_checker
// follows the job and result channels of the scheduler, works out the
// completion, waiting and turnaround time of every job in a set and compares
// each result beat with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module schedule_checker #(
    parameter int SLOTS     = ppsu_pkg::MAX_PROCESSES_DEF,
    parameter int TIME_BITS = ppsu_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ppsu_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ppsu_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             due_count
);
    import ppsu_pkg::*;

    localparam int              NONE_PICKED = -1;
    localparam int              REPORT_MAX  = 10;
    localparam longint unsigned TIME_MASK   =
        (TIME_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << TIME_BITS) - 64'd1);

    typedef struct packed {
        logic [JOB_INDEX_W-1:0] job_index;
        logic [OUT_TIME_W-1:0]  completion;
        logic [OUT_TIME_W-1:0]  waiting;
        logic [OUT_TIME_W-1:0]  turnaround;
        logic                   last_flag;
    } job_times_t;

    job_times_t        due_times[$];
    longint unsigned   arrival_at[SLOTS];
    longint unsigned   burst_len[SLOTS];
    longint unsigned   left_len[SLOTS];
    longint unsigned   done_at[SLOTS];
    logic [PRIORITY_W-1:0] prio_of[SLOTS];
    int                jobs_loaded = 0;
    int                failures    = 0;

    function automatic logic [OUT_TIME_W-1:0] clip_time(longint unsigned v);
        return (v > OUT_TIME_MAX) ? OUT_TIME_MAX : v[OUT_TIME_W-1:0];
    endfunction

    // runs the preemptive schedule of the loaded set and queues its results
    task automatic schedule_jobs();
        longint unsigned tick, next_arrival, run_len, turn;
        int              pick, finished, i;
        bit              have_next;
        job_times_t      rec;
        tick     = 0;
        finished = 0;
        for (i = 0; i < jobs_loaded; i++) begin
            if (left_len[i] == 0) begin
                done_at[i] = arrival_at[i];
                finished++;
            end
        end
        while (finished < jobs_loaded) begin
            pick         = NONE_PICKED;
            have_next    = 1'b0;
            next_arrival = 0;
            for (i = 0; i < jobs_loaded; i++) begin
                if (left_len[i] != 0) begin
                    if (arrival_at[i] <= tick) begin
                        if (pick == NONE_PICKED || prio_of[i] > prio_of[pick])
                            pick = i;
                    end else if (!have_next || arrival_at[i] < next_arrival) begin
                        next_arrival = arrival_at[i];
                        have_next    = 1'b1;
                    end
                end
            end
            if (pick == NONE_PICKED) begin
                // nobody ready, jump to the next arrival
                tick = next_arrival;
            end else begin
                run_len = left_len[pick];
                if (have_next && next_arrival - tick < run_len)
                    run_len = next_arrival - tick;
                tick           += run_len;
                left_len[pick] -= run_len;
                if (left_len[pick] == 0) begin
                    done_at[pick] = tick;
                    finished++;
                end
            end
        end
        for (i = 0; i < jobs_loaded; i++) begin
            turn           = done_at[i] - arrival_at[i];
            rec.job_index  = JOB_INDEX_W'(i);
            rec.completion = clip_time(done_at[i]);
            rec.turnaround = clip_time(turn);
            rec.waiting    = clip_time(turn - burst_len[i]);
            rec.last_flag  = (i == jobs_loaded - 1);
            due_times.push_back(rec);
        end
        jobs_loaded = 0;
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_beat();
        job_times_t seen, want;
        seen.job_index  = m_tdata[5:0];
        seen.completion = m_tdata[26:6];
        seen.waiting    = m_tdata[47:27];
        seen.turnaround = m_tdata[68:48];
        seen.last_flag  = m_tlast;
        if (due_times.size() == 0) begin
            note_failure($sformatf(
                "result beat with nothing due: job %0d cpl %0d wait %0d tat %0d last %0b",
                seen.job_index, seen.completion, seen.waiting, seen.turnaround,
                seen.last_flag));
        end else begin
            want = due_times.pop_front();
            if (seen.job_index !== want.job_index || seen.completion !== want.completion ||
                seen.waiting !== want.waiting || seen.turnaround !== want.turnaround ||
                seen.last_flag !== want.last_flag)
                note_failure($sformatf({"expected job %0d cpl %0d wait %0d tat %0d last %0b, ",
                                        "got job %0d cpl %0d wait %0d tat %0d last %0b"},
                    want.job_index, want.completion, want.waiting, want.turnaround,
                    want.last_flag, seen.job_index, seen.completion, seen.waiting,
                    seen.turnaround, seen.last_flag));
        end
    endtask

    task automatic load_job();
        arrival_at[jobs_loaded] = longint'(s_tdata[15:0]) & TIME_MASK;
        burst_len[jobs_loaded]  = longint'(s_tdata[31:16]) & TIME_MASK;
        left_len[jobs_loaded]   = burst_len[jobs_loaded];
        prio_of[jobs_loaded]    = s_tdata[39:32];
        jobs_loaded++;
        // a full store starts the schedule even without tlast
        if (s_tlast || jobs_loaded == SLOTS)
            schedule_jobs();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            jobs_loaded = 0;
            due_times.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                load_job();
        end
        due_count      <= due_times.size();
        mismatch_count <= failures;
    end

endmodule

>>> verif/preemptive_priority_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_tb
// feeds job sets into the scheduler, directed corner sets first and then
// random sets of mixed size, with random gaps on both channels; the checker
// beside the block predicts every result beat and this top gives the verdict
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_tb;
    import ppsu_pkg::*;

    localparam int SLOTS        = MAX_PROCESSES_DEF;
    localparam int IDLE_PCT     = 24;     // chance of a gap cycle on either side
    localparam int RANDOM_JOBS  = 85;     // random loads before the run winds down
    localparam int QUIET_LIMIT  = 20000;  // cycles with no beat before giving up
    localparam int DRAIN_CYCLES = 64;     // settle time after the last result

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // arrival_time, burst_time, priority_level
    logic                 s_tlast;    // last_job
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // job_index, completion_time, waiting_time,
                                      // turnaround_time, pad
    logic                 m_tlast;    // last_result

    int idle_pct     = IDLE_PCT;
    int quiet_cycles = 0;
    int mismatch_count;
    int due_count;

    preemptive_priority_scheduler_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    schedule_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side backpressure, redrawn every falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // watchdog: any accepted beat on either channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // one job beat: random gap cycles first, then hold until the block takes it
    task automatic send_job(input logic [15:0] arrival, input logic [15:0] burst,
                            input logic [7:0] prio, input logic last);
        @(negedge aclk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, burst, arrival};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop tvalid and let the block drain everything it owes
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (due_count == 0);
    endtask

    initial begin
        int unsigned set_size, jobs_sent, set_no, mode, idx;
        bit          stop_on_full;
        logic [15:0] arrival, burst;
        logic [7:0]  prio;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // lone job with every field at its top value
        send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // lone job at the bottom, one tick of service
        send_job(16'h0000, 16'h0001, 8'h00, 1'b1);
        // preemption by a later arrival, equal-priority tie to the lower index,
        // a zero-burst job, and an idle gap before the last arrival
        send_job(16'd0,  16'd10, 8'd1, 1'b0);
        send_job(16'd2,  16'd3,  8'd5, 1'b0);
        send_job(16'd2,  16'd4,  8'd5, 1'b0);
        send_job(16'd50, 16'd0,  8'd9, 1'b0);
        send_job(16'd30, 16'd5,  8'd0, 1'b1);
        // full store with tlast never set, zero bursts mixed in
        for (idx = 0; idx < SLOTS; idx++)
            send_job(16'(idx * 3), (idx % 3 == 0) ? 16'd0 : 16'(idx + 1), 8'(idx % 4), 1'b0);

        // sender holds off until every directed result is back
        drain_results();

        jobs_sent = 0;
        set_no    = 0;
        while (jobs_sent < RANDOM_JOBS) begin
            mode = $urandom_range(0, 99);
            if (mode < 70)
                set_size = $urandom_range(1, 5);
            else if (mode < 90)
                set_size = $urandom_range(6, SLOTS - 1);
            else
                set_size = SLOTS;
            stop_on_full = $urandom_range(0, 1);
            // a run of sets with no gaps on either channel
            idle_pct = (set_no >= 8 && set_no < 16) ? 0 : IDLE_PCT;
            for (idx = 0; idx < set_size; idx++) begin
                // arrivals mostly clustered near zero so jobs contend
                mode = $urandom_range(0, 9);
                if (mode < 6)
                    arrival = 16'($urandom_range(0, 40));
                else if (mode < 9)
                    arrival = 16'($urandom);
                else
                    arrival = 16'($urandom_range(65500, 65535));
                // short bursts mostly, plus full-range, zero and maximum
                mode = $urandom_range(0, 19);
                if (mode < 12)
                    burst = 16'($urandom_range(1, 25));
                else if (mode < 16)
                    burst = 16'($urandom);
                else if (mode < 18)
                    burst = 16'd0;
                else
                    burst = 16'hFFFF;
                // few distinct priorities half the time to force ties
                prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                send_job(arrival, burst, prio,
                         (idx == set_size - 1) && !(set_size == SLOTS && stop_on_full));
            end
            jobs_sent += set_size;
            set_no++;
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && due_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
